// ===== rtl/glp_pkg.sv =====
// glp_pkg: shared types, constants and helpers for the glyph pen layout core.
// No dependencies; used by glyph_pen_layout_core, glp_sva, glp_checker and the testbench.
package glp_pkg;

    // default glyph table depth
    localparam int GLYPH_COUNT_DEF = 128;

    // field widths
    localparam int CODE_W  = 7;
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 8;
    localparam int IN_DATA_W  = 56;   // 7+8+8+1+16+16
    localparam int OUT_DATA_W = 56;   // 7+16+16+16, one pad bit
    localparam int CFG_ADDR_W = 2;

    // scaled magnitude: |v| <= 383, times print size <= 255 -> 17 bits
    localparam int DIV_W   = 17;
    localparam int LANES   = 3;
    localparam int DCNT_W  = $clog2(DIV_W);

    // character codes
    localparam logic [CODE_W-1:0] CODE_NEWLINE = 7'd10;
    localparam logic [CODE_W-1:0] CODE_SPACE   = 7'd32;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_LOADED_SIZE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRINT_SIZE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_HEIGHT = 2'd2;

    // configuration reset values
    localparam logic [SIZE_W-1:0] LOADED_SIZE_RST = 8'd16;
    localparam logic [SIZE_W-1:0] PRINT_SIZE_RST  = 8'd0;
    localparam logic [SIZE_W-1:0] LINE_HEIGHT_RST = 8'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_POST1,
        S_POST2,
        S_EMIT
    } state_t;

    // clamp a 19-bit signed sum to signed 16 bits
    function automatic logic signed [15:0] sat_s16(input logic signed [18:0] v);
        if (v > 19'sd32767) begin
            return 16'sd32767;
        end else if (v < -19'sd32768) begin
            return -16'sd32768;
        end else begin
            return v[15:0];
        end
    endfunction

endpackage

// ===== rtl/glyph_pen_layout_core.sv =====
// glyph_pen_layout_core: pen-advance text layout with a glyph metric memory.
// Depends on glp_pkg (types, constants, saturation helper).
//
// Usage:
//   Input stream s_*: s_tuser = kind (0 metric write, 1 character).
//   s_tdata carries glyph, bearing_x, advance, first, origin_x, origin_y.
//   Output stream m_*: one transaction per input transaction, m_tuser = draw,
//   m_tdata carries glyph_out, pos_x, pos_y, text_width.
//   Config port: cfg_we/cfg_addr/cfg_wdata write loaded size, print size and
//   line height; only while the core is idle.
// Flow:
//   Metric write: accept, then S_EMIT loads the output register once it is free.
//   Character: memory read on the accept edge, S_LOAD for the three scale
//   multiplies, S_DIV for the bit-serial divide (three lanes run side by side:
//   bearing or line height, advance - bearing, advance), S_POST1 and S_POST2
//   for the pen / width updates, S_EMIT to load the output register.
//   One item in flight; s_tready is high only when idle.
// Reset: pen, line start and width clear to zero, config to defaults. The
//   metric memory is not cleared; unwritten glyphs read back garbage.
// Stall: the output register holds a finished result while m_tready is low;
//   the core still takes the next item and parks it before the output stage.
module glyph_pen_layout_core #(
    parameter int GLYPH_COUNT = glp_pkg::GLYPH_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [glp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [glp_pkg::SIZE_W-1:0]        cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [6:0] glyph, [14:7] bearing_x, [22:15] advance, [23] first,
    // [39:24] origin_x, [55:40] origin_y
    input  logic [glp_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,   // kind
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [6:0] glyph_out, [22:7] pos_x, [38:23] pos_y, [54:39] text_width, [55] zero
    output logic [glp_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tuser    // draw
);

    localparam int GI_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int DW   = glp_pkg::DIV_W;
    localparam int NL   = glp_pkg::LANES;

    // ---------------- input field unpack ----------------
    logic [6:0]         in_glyph;
    logic [7:0]         in_bearing;
    logic [7:0]         in_advance;
    logic               in_first;
    logic signed [15:0] in_origin_x;
    logic signed [15:0] in_origin_y;
    logic               s_fire;
    logic               in_range;
    logic [GI_W-1:0]    in_idx;

    assign in_glyph    = s_tdata[6:0];
    assign in_bearing  = s_tdata[14:7];
    assign in_advance  = s_tdata[22:15];
    assign in_first    = s_tdata[23];
    assign in_origin_x = s_tdata[39:24];
    assign in_origin_y = s_tdata[55:40];
    assign s_fire      = s_tvalid && s_tready;
    assign in_range    = 32'(in_glyph) < 32'(GLYPH_COUNT);
    assign in_idx      = GI_W'(in_glyph);

    // ---------------- configuration ----------------
    logic [7:0] loaded_reg, print_reg, line_reg;
    logic [7:0] div_l, mul_p;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= glp_pkg::LOADED_SIZE_RST;
            print_reg  <= glp_pkg::PRINT_SIZE_RST;
            line_reg   <= glp_pkg::LINE_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                glp_pkg::CFG_LOADED_SIZE: loaded_reg <= cfg_wdata;
                glp_pkg::CFG_PRINT_SIZE:  print_reg  <= cfg_wdata;
                glp_pkg::CFG_LINE_HEIGHT: line_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // loaded size 0 acts as 1; print size 0 means loaded size
    assign div_l = (loaded_reg == 8'd0) ? 8'd1 : loaded_reg;
    assign mul_p = (print_reg == 8'd0) ? div_l : print_reg;

    // ---------------- metric memory ----------------
    // entry = {advance, bearing}; one write or one read per accepted item,
    // so a read never meets a write to the same entry in the same cycle
    logic [15:0] glyph_mem [GLYPH_COUNT];
    logic [15:0] mem_rd_reg;

    always_ff @(posedge aclk) begin
        if (s_fire && in_range) begin
            if (!s_tuser) begin
                glyph_mem[in_idx] <= {in_advance, in_bearing};
            end else begin
                mem_rd_reg <= glyph_mem[in_idx];
            end
        end
    end

    // ---------------- control ----------------
    glp_pkg::state_t state_reg, state_next;
    logic [glp_pkg::DCNT_W-1:0] dcnt_reg;
    logic out_free;
    logic m_tvalid_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == glp_pkg::S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= glp_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            glp_pkg::S_IDLE: begin
                if (s_fire) begin
                    state_next = s_tuser ? glp_pkg::S_LOAD : glp_pkg::S_EMIT;
                end
            end
            glp_pkg::S_LOAD:  state_next = glp_pkg::S_DIV;
            glp_pkg::S_DIV: begin
                if (dcnt_reg == glp_pkg::DCNT_W'(DW - 1)) begin
                    state_next = glp_pkg::S_POST1;
                end
            end
            glp_pkg::S_POST1: state_next = glp_pkg::S_POST2;
            glp_pkg::S_POST2: state_next = glp_pkg::S_EMIT;
            glp_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = glp_pkg::S_IDLE;
                end
            end
            default: state_next = glp_pkg::S_IDLE;
        endcase
    end

    // ---------------- item registers ----------------
    logic       kind_reg;
    logic [6:0] code_reg;
    logic       range_reg;
    logic       newline;

    assign newline = (code_reg == glp_pkg::CODE_NEWLINE);

    // ---------------- scale operands (S_LOAD) ----------------
    logic signed [7:0] bear;
    logic [7:0]        adv;
    logic signed [9:0] opnd [NL];
    logic [8:0]        mag  [NL];

    assign bear = range_reg ? $signed(mem_rd_reg[7:0]) : 8'sd0;
    assign adv  = range_reg ? mem_rd_reg[15:8] : 8'd0;

    always_comb begin
        opnd[0] = newline ? $signed({2'b00, line_reg}) : $signed({{2{bear[7]}}, bear});
        opnd[1] = $signed({2'b00, adv}) - $signed({{2{bear[7]}}, bear});
        opnd[2] = $signed({2'b00, adv});
        for (int i = 0; i < NL; i++) begin
            mag[i] = opnd[i][9] ? 9'(-opnd[i]) : opnd[i][8:0];
        end
    end

    // ---------------- divider lanes ----------------
    // restoring divide, one quotient bit per cycle; dq holds the dividend
    // and shifts the quotient in from the bottom
    logic [DW-1:0] dq_reg  [NL];
    logic [7:0]    rem_reg [NL];
    logic          neg_reg [NL];
    logic [8:0]    shifted [NL];
    logic          ge      [NL];
    logic signed [DW:0] q_s [NL];

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            shifted[i] = {rem_reg[i], dq_reg[i][DW-1]};
            ge[i]      = shifted[i] >= {1'b0, div_l};
            q_s[i]     = neg_reg[i] ? -$signed({1'b0, dq_reg[i]}) : $signed({1'b0, dq_reg[i]});
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == glp_pkg::S_LOAD) begin
            dcnt_reg <= '0;
            for (int i = 0; i < NL; i++) begin
                dq_reg[i]  <= DW'(mag[i]) * DW'(mul_p);
                rem_reg[i] <= '0;
                neg_reg[i] <= opnd[i][9];
            end
        end else if (state_reg == glp_pkg::S_DIV) begin
            dcnt_reg <= dcnt_reg + 1'b1;
            for (int i = 0; i < NL; i++) begin
                dq_reg[i]  <= {dq_reg[i][DW-2:0], ge[i]};
                rem_reg[i] <= ge[i] ? 8'(shifted[i] - {1'b0, div_l}) : shifted[i][7:0];
            end
        end
    end

    // ---------------- pen state ----------------
    logic signed [15:0] pen_x_reg, pen_y_reg, line_x_reg;
    logic [15:0]        width_reg;
    logic signed [18:0] sum_x, diff_y;
    logic [17:0]        wsum;
    logic signed [15:0] pen_x_next, pen_y_next;
    logic [15:0]        width_next;

    assign sum_x  = {{3{pen_x_reg[15]}}, pen_x_reg}
                  + {q_s[state_reg == glp_pkg::S_POST1 ? 0 : 1][DW], 
                     q_s[state_reg == glp_pkg::S_POST1 ? 0 : 1]};
    assign diff_y = {{3{pen_y_reg[15]}}, pen_y_reg} - {q_s[0][DW], q_s[0]};
    assign wsum   = {2'b00, width_reg} + {1'b0, dq_reg[2]};

    always_comb begin
        pen_x_next = glp_pkg::sat_s16(sum_x);
        pen_y_next = glp_pkg::sat_s16(diff_y);
        width_next = (wsum > 18'd65535) ? 16'hFFFF : wsum[15:0];
    end

    logic               draw_reg;
    logic signed [15:0] res_x_reg, res_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            line_x_reg <= '0;
            width_reg  <= '0;
        end else begin
            case (state_reg)
                glp_pkg::S_IDLE: begin
                    if (s_fire && s_tuser && in_first) begin
                        pen_x_reg  <= in_origin_x;
                        pen_y_reg  <= in_origin_y;
                        line_x_reg <= in_origin_x;
                        width_reg  <= '0;
                    end
                end
                glp_pkg::S_POST1: begin
                    if (newline) begin
                        pen_x_reg <= line_x_reg;
                        pen_y_reg <= pen_y_next;
                    end else begin
                        pen_x_reg <= pen_x_next;   // after bearing
                    end
                end
                glp_pkg::S_POST2: begin
                    if (!newline) begin
                        pen_x_reg <= pen_x_next;   // rest of the advance
                        width_reg <= width_next;
                    end
                end
                default: ;
            endcase
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            glp_pkg::S_IDLE: begin
                if (s_fire) begin
                    kind_reg  <= s_tuser;
                    code_reg  <= in_glyph;
                    range_reg <= in_range;
                    draw_reg  <= 1'b0;
                    res_x_reg <= pen_x_reg;   // metric writes report current pen
                    res_y_reg <= pen_y_reg;
                end
            end
            glp_pkg::S_POST1: begin
                if (newline) begin
                    res_x_reg <= line_x_reg;
                    res_y_reg <= pen_y_next;
                end else begin
                    res_x_reg <= pen_x_next;
                    res_y_reg <= pen_y_reg;
                    draw_reg  <= (code_reg != glp_pkg::CODE_SPACE);
                end
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    logic [6:0]  m_glyph_reg;
    logic [15:0] m_x_reg, m_y_reg, m_w_reg;
    logic        m_draw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == glp_pkg::S_EMIT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == glp_pkg::S_EMIT && out_free) begin
            m_glyph_reg <= kind_reg ? code_reg : 7'd0;
            m_x_reg     <= res_x_reg;
            m_y_reg     <= res_y_reg;
            m_w_reg     <= width_reg;
            m_draw_reg  <= draw_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_draw_reg;
    assign m_tdata  = {1'b0, m_w_reg, m_y_reg, m_x_reg, m_glyph_reg};

endmodule

// ===== rtl/glp_checker.sv =====
// glp_sva: port-level assertions for glyph_pen_layout_core, bound in below.
// Depends on glp_pkg for field widths and character codes.
module glp_sva (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [glp_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic                              m_tuser
);

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // one item at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a second item back to back");

    // newline and space never draw
    a_no_draw_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (m_tdata[6:0] != glp_pkg::CODE_NEWLINE && m_tdata[6:0] != glp_pkg::CODE_SPACE))
        else $error("draw flagged for newline or space");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind glyph_pen_layout_core glp_sva u_glp_sva (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/glp_checker.sv =====
`timescale 1ns / 1ps
// glp_checker: passive layout checker for glyph_pen_layout_core.
// Watches config writes and both streams, predicts each result and compares it.
// Depends on glp_pkg for widths, register indexes, reset values and glyph codes.
module glp_checker #(
    parameter int GLYPH_COUNT = glp_pkg::GLYPH_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [glp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [glp_pkg::SIZE_W-1:0]     cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [glp_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [glp_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           m_tuser,
    output int                             fail_count,
    output int                             pending,
    output int                             results_seen,
    output int                             draws_seen
);

    typedef struct packed {
        logic        draw;
        logic [6:0]  glyph;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] width;
    } layout_result_t;

    layout_result_t placement_q[$];
    layout_result_t want;

    // shadow of the size registers and pen state
    logic [glp_pkg::SIZE_W-1:0] sz_loaded, sz_print, sz_line;
    int cur_x, cur_y, row_x, run_width;
    logic [7:0] bear_mem [GLYPH_COUNT];
    logic [7:0] adv_mem  [GLYPH_COUNT];

    logic [glp_pkg::CODE_W-1:0] code;
    logic              is_char;
    int                bear_i, adv_i, bad;

    int n_fail = 0;
    int n_pending = 0;
    int n_results = 0;
    int n_draws = 0;

    assign fail_count   = n_fail;
    assign pending      = n_pending;
    assign results_seen = n_results;
    assign draws_seen   = n_draws;

    // v * print / loaded, truncated toward zero; zero sizes fall back
    function automatic int size_scale(int v);
        int div_by;
        int mul_by;
        div_by = (sz_loaded == 0) ? 1 : int'(sz_loaded);
        mul_by = (sz_print == 0) ? div_by : int'(sz_print);
        return (v * mul_by) / div_by;
    endfunction

    function automatic int clamp_s16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int field_diff(string label, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: mismatch on %s: expected 0x%0h, actual 0x%0h",
                     $time, label, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            sz_loaded = glp_pkg::LOADED_SIZE_RST;
            sz_print  = glp_pkg::PRINT_SIZE_RST;
            sz_line   = glp_pkg::LINE_HEIGHT_RST;
            cur_x     = 0;
            cur_y     = 0;
            row_x     = 0;
            run_width = 0;
            placement_q.delete();
            n_pending = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    glp_pkg::CFG_LOADED_SIZE: sz_loaded = cfg_wdata;
                    glp_pkg::CFG_PRINT_SIZE:  sz_print  = cfg_wdata;
                    glp_pkg::CFG_LINE_HEIGHT: sz_line   = cfg_wdata;
                    default: ;
                endcase
            end

            // result side first: a result never belongs to an item taken on the same edge
            if (m_tvalid && m_tready) begin
                n_results++;
                if (m_tuser) n_draws++;
                if (placement_q.size() == 0) begin
                    $display("%0t ns: unexpected result, actual tuser=%0b tdata=0x%0h",
                             $time, m_tuser, m_tdata);
                    n_fail++;
                end else begin
                    want = placement_q.pop_front();
                    bad = field_diff("draw", want.draw, m_tuser)
                        + field_diff("glyph_out", want.glyph, m_tdata[6:0])
                        + field_diff("pos_x", want.pos_x, m_tdata[22:7])
                        + field_diff("pos_y", want.pos_y, m_tdata[38:23])
                        + field_diff("text_width", want.width, m_tdata[54:39])
                        + field_diff("pad", 0, m_tdata[55]);
                    if (bad != 0) n_fail++;
                end
            end

            if (s_tvalid && s_tready) begin
                code    = s_tdata[6:0];
                is_char = s_tuser;
                want    = '0;
                if (!is_char) begin
                    if (code < GLYPH_COUNT) begin
                        bear_mem[code] = s_tdata[14:7];
                        adv_mem[code]  = s_tdata[22:15];
                    end
                end else begin
                    want.glyph = code;
                    if (s_tdata[23]) begin
                        cur_x     = $signed(s_tdata[39:24]);
                        cur_y     = $signed(s_tdata[55:40]);
                        row_x     = cur_x;
                        run_width = 0;
                    end
                    if (code == glp_pkg::CODE_NEWLINE) begin
                        cur_x = row_x;
                        cur_y = clamp_s16(cur_y - size_scale(int'(sz_line)));
                    end else begin
                        bear_i = 0;
                        adv_i  = 0;
                        if (code < GLYPH_COUNT) begin
                            bear_i = $signed(bear_mem[code]);
                            adv_i  = int'(adv_mem[code]);
                        end
                        cur_x = clamp_s16(cur_x + size_scale(bear_i));
                        want.draw = (code != glp_pkg::CODE_SPACE);
                    end
                end
                want.pos_x = cur_x[15:0];
                want.pos_y = cur_y[15:0];
                // the rest of the advance comes after the draw position is taken
                if (is_char && code != glp_pkg::CODE_NEWLINE) begin
                    cur_x = clamp_s16(cur_x + size_scale(adv_i - bear_i));
                    run_width = run_width + size_scale(adv_i);
                    if (run_width > 65535) run_width = 65535;
                end
                want.width = run_width[15:0];
                placement_q.push_back(want);
            end
            n_pending = placement_q.size();
        end
    end

endmodule

// ===== dv/glyph_pen_layout_core_tb.sv =====
`timescale 1ns / 1ps
// glyph_pen_layout_core_tb: stimulus and verdict for the glyph pen layout core.
// Depends on glp_pkg, glyph_pen_layout_core and glp_checker (prediction and compare).
module glyph_pen_layout_core_tb;

    localparam logic KIND_METRIC = 1'b0;
    localparam logic KIND_CHAR   = 1'b1;
    localparam logic [glp_pkg::CODE_W-1:0] GLYPH_A   = 7'd65;
    localparam logic [glp_pkg::CODE_W-1:0] GLYPH_MAX = 7'd127;
    // watchdog limit; keeps plenty of margin over the slowest legal run
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 78;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [glp_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [glp_pkg::SIZE_W-1:0]     cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [glp_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [glp_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tuser;

    int fail_count, pending, results_seen, draws_seen;

    // stimulus bookkeeping
    bit written [128];         // glyphs whose metrics were loaded; only these get placed
    int n_written = 0;
    int n_items   = 0;
    int n_metric  = 0;
    int n_texts   = 0;
    int n_phases  = 0;
    int burst_left = 0;
    int phase_start, pick;

    // receiver stall pattern state
    int rx_mode = 0;
    int rx_left = 0;

    int unsigned cycle_count = 0;

    glyph_pen_layout_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        // [6:0] glyph, [14:7] bearing_x, [22:15] advance, [23] first,
        // [39:24] origin_x, [55:40] origin_y
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),   // kind
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // [6:0] glyph_out, [22:7] pos_x, [38:23] pos_y, [54:39] text_width, [55] zero
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)    // draw
    );

    glp_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .draws_seen   (draws_seen)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // watchdog: a hung handshake or a lost result ends up here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: cycle limit reached, %0d results outstanding", $time, pending);
            $display("status: fail");
            $finish;
        end
    end

    // Receiver back-pressure, in modes picked at random:
    // always ready, coin flip, mostly ready, and long stalls (ready ~1 in 32).
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= ($urandom_range(0, 31) == 0);
        endcase
    end

    function automatic logic [glp_pkg::IN_DATA_W-1:0] pack_item(logic [6:0] code,
                                                                logic [7:0] bear,
                                                                logic [7:0] adv, logic first,
                                                                logic [15:0] ox,
                                                                logic [15:0] oy);
        return {oy, ox, first, adv, bear, code};
    endfunction

    // origins lean on the saturation corners
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 400) - 200);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // any glyph whose metrics are loaded; never an unwritten table entry
    function automatic logic [6:0] pick_glyph();
        logic [6:0] c;
        for (int k = 0; k < 32; k++) begin
            c = 7'($urandom_range(0, 127));
            if (written[c]) return c;
        end
        return GLYPH_A;
    endfunction

    // Drive one transaction at the falling edge and hold it until accepted.
    // The sender runs in bursts of 1..16 transactions, with or without an idle gap between.
    task automatic push_item(input logic kind, input logic [glp_pkg::IN_DATA_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        n_items++;
    endtask

    task automatic send_metric(input logic [6:0] code, input logic [7:0] bear,
                               input logic [7:0] adv);
        // first/origin are don't-care on metric writes; randomize them anyway
        push_item(KIND_METRIC, pack_item(code, bear, adv, 1'($urandom_range(0, 1)),
                                         rand_coord(), rand_coord()));
        if (!written[code]) n_written++;
        written[code] = 1'b1;
        n_metric++;
    endtask

    task automatic send_char(input logic [6:0] code, input logic first,
                             input logic [15:0] ox, input logic [15:0] oy);
        // bearing/advance fields are ignored on characters
        push_item(KIND_CHAR, pack_item(code, 8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)), first, ox, oy));
        if (first) n_texts++;
    endtask

    // drop valid and let every outstanding result drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // size registers change only with the core idle
    task automatic set_sizes(input logic [7:0] loaded, input logic [7:0] printed,
                             input logic [7:0] line);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_addr  <= glp_pkg::CFG_LOADED_SIZE;
        cfg_wdata <= loaded;
        @(negedge aclk);
        cfg_addr  <= glp_pkg::CFG_PRINT_SIZE;
        cfg_wdata <= printed;
        @(negedge aclk);
        cfg_addr  <= glp_pkg::CFG_LINE_HEIGHT;
        cfg_wdata <= line;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        n_phases++;
    endtask

    // one text: origin on the first character, then newlines, spaces and glyphs
    task automatic random_text();
        int len;
        int roll;
        logic [6:0] c;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) c = glp_pkg::CODE_NEWLINE;
            else if (roll < 22) c = glp_pkg::CODE_SPACE;
            else c = pick_glyph();
            send_char(c, i == 0, rand_coord(), rand_coord());
        end
    endtask

    initial begin
        // reset held low at start, released on a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed, reset sizes (identity scale) ----
        send_metric(7'd0, 8'h80, 8'hFF);          // most negative bearing, widest advance
        send_metric(GLYPH_MAX, 8'h7F, 8'h00);     // most positive bearing, zero advance
        send_metric(GLYPH_A, 8'd2, 8'd10);
        send_metric(glp_pkg::CODE_SPACE, 8'd0, 8'd8);
        send_metric(7'd33, 8'hFF, 8'd0);          // bearing -1
        send_char(GLYPH_A, 1'b0, 16'h0, 16'h0);   // pen straight out of reset
        send_char(glp_pkg::CODE_NEWLINE, 1'b0, 16'h0, 16'h0);
        send_char(glp_pkg::CODE_SPACE, 1'b0, 16'h0, 16'h0);
        send_char(GLYPH_A, 1'b1, 16'h7FFF, 16'h8000);   // x saturates high
        send_char(GLYPH_MAX, 1'b0, 16'h0, 16'h0);
        send_char(glp_pkg::CODE_NEWLINE, 1'b0, 16'h0, 16'h0);    // y saturates low
        send_char(7'd0, 1'b1, 16'h8000, 16'h7FFF);      // x saturates low
        send_metric(7'd5, 8'd3, 8'd4);                  // metric write inside a text
        send_char(7'd33, 1'b0, 16'h0, 16'h0);
        send_char(7'd5, 1'b1, 16'h0, 16'h0);
        send_char(glp_pkg::CODE_NEWLINE, 1'b1, 16'd100, 16'd200); // newline opens a text
        send_char(glp_pkg::CODE_SPACE, 1'b1, 16'hFFFB, 16'd7);

        // ---- directed, largest up-scale: width and newline saturate ----
        set_sizes(8'd1, 8'd255, 8'd255);
        send_char(7'd0, 1'b1, 16'h0, 16'h0);
        send_char(7'd0, 1'b0, 16'h0, 16'h0);
        send_char(glp_pkg::CODE_NEWLINE, 1'b0, 16'h0, 16'h0);
        send_char(GLYPH_MAX, 1'b0, 16'h0, 16'h0);

        // ---- directed, fractional scale: truncation toward zero ----
        set_sizes(8'd3, 8'd2, 8'd7);
        send_char(7'd33, 1'b1, 16'd10, 16'd10);
        send_char(GLYPH_A, 1'b0, 16'h0, 16'h0);
        send_char(glp_pkg::CODE_NEWLINE, 1'b0, 16'h0, 16'h0);

        // ---- random phases, one size setting each ----
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: set_sizes(8'd16, 8'd0, 8'd16);
                1: set_sizes(8'd255, 8'd1, 8'd0);
                2: set_sizes(8'd0, 8'd5, 8'd3);       // loaded size zero acts as one
                3: set_sizes(8'd1, 8'd255, 8'd255);
                4: set_sizes(8'd7, 8'd13, 8'd200);
                5: set_sizes(8'd255, 8'd255, 8'd255);
                default: set_sizes(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)));
            endcase
            phase_start = n_items;
            while (n_items - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                // load metrics heavily until a good part of the font exists
                if (pick < ((n_written < 48) ? 40 : 10)) begin
                    send_metric(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
                end else if (pick < ((n_written < 48) ? 45 : 16)) begin
                    // stray character: may continue a text or restart one mid-stream
                    send_char(pick_glyph(), 1'($urandom_range(0, 1)),
                              rand_coord(), rand_coord());
                end else begin
                    random_text();
                end
            end
        end

        // drain, then keep the clock running to catch any extra result
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);

        $display("covered %0d input transactions (%0d metric writes, %0d texts), %0d sizes",
                 n_items, n_metric, n_texts, n_phases);
        $display("%0d results checked, %0d of them drawn glyphs, %0d failures",
                 results_seen, draws_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/glp_pkg.sv
rtl/glyph_pen_layout_core.sv
rtl/glp_checker.sv
dv/glp_checker.sv
dv/glyph_pen_layout_core_tb.sv
